@@ hw/rtl/sgsq_pkg.sv @@
// ----------------------------------------------------------------------------
// sgsq_pkg: shared constants for the scroll gesture switch qualifier
// Widths, decision, phase and direction codes, request kinds, register indexes and register reset values.
// ----------------------------------------------------------------------------
package sgsq_pkg;

  // Default widths
  localparam int unsigned TIME_BITS_DEF   = 48;
  localparam int unsigned OFFSET_BITS_DEF = 24;

  // Fixed field widths
  localparam int unsigned ACC_BITS       = 32;
  localparam int unsigned DEC_BITS       = 3;
  localparam int unsigned DPHASE_BITS    = 2;
  localparam int unsigned MPHASE_BITS    = 3;
  localparam int unsigned CFG_INDEX_BITS = 8;
  localparam int unsigned CFG_DATA_BITS  = 32;
  localparam int unsigned DIR_BITS       = 2;

  // Decision codes
  localparam logic [DEC_BITS-1:0] DEC_NONE      = 3'd0;
  localparam logic [DEC_BITS-1:0] DEC_CONSUME   = 3'd1;
  localparam logic [DEC_BITS-1:0] DEC_PREV_NEXT = 3'd2;
  localparam logic [DEC_BITS-1:0] DEC_PREV_PREV = 3'd3;
  localparam logic [DEC_BITS-1:0] DEC_SW_NEXT   = 3'd4;
  localparam logic [DEC_BITS-1:0] DEC_SW_PREV   = 3'd5;

  // Direct phase codes
  localparam logic [DPHASE_BITS-1:0] DP_NONE   = 2'd0;
  localparam logic [DPHASE_BITS-1:0] DP_BEGAN  = 2'd1;
  localparam logic [DPHASE_BITS-1:0] DP_UPDATE = 2'd2;
  localparam logic [DPHASE_BITS-1:0] DP_END    = 2'd3;

  // Momentum phase codes
  localparam logic [MPHASE_BITS-1:0] MP_NONE      = 3'd0;
  localparam logic [MPHASE_BITS-1:0] MP_BEGAN     = 3'd1;
  localparam logic [MPHASE_BITS-1:0] MP_MAY_BEGIN = 3'd2;
  localparam logic [MPHASE_BITS-1:0] MP_INERTIAL  = 3'd3;
  localparam logic [MPHASE_BITS-1:0] MP_END       = 3'd4;
  localparam logic [MPHASE_BITS-1:0] MP_BLOCKED   = 3'd5;

  // Direction codes
  localparam logic [DIR_BITS-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_BITS-1:0] DIR_POS  = 2'd1;
  localparam logic [DIR_BITS-1:0] DIR_NEG  = 2'd2;

  // Request kinds
  localparam logic REQ_SCROLL = 1'b0;
  localparam logic REQ_CANCEL = 1'b1;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE    = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_INTV  = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT   = 8'd3;

  // Register reset values
  localparam logic                RST_ENABLE    = 1'b1;
  localparam logic [ACC_BITS-1:0] RST_THRESHOLD = 32'd2560;
  localparam logic [ACC_BITS-1:0] RST_MIN_INTV  = 32'd0;
  localparam logic [ACC_BITS-1:0] RST_TIMEOUT   = 32'd400000;

endpackage

@@ hw/rtl/scroll_gesture_switch_qualifier.sv @@
// ----------------------------------------------------------------------------
// scroll_gesture_switch_qualifier: switch gesture decision per scroll event
// Registers each beat, qualifies it combinationally against the gesture state
// and holds the decision in a result register.
// ----------------------------------------------------------------------------
// Path: input register, combinational qualify step, then the result register.
// Throughput: one beat per cycle while the result stream is not stalled; the
// qualify step is one add, a saturate and two timestamp compares on registered state.
// Reset: rst_ni is asynchronous, active low; it clears all gesture state,
// both valid flags and the result decision, and loads the register defaults.
module scroll_gesture_switch_qualifier #(
  parameter int unsigned TIME_BITS   = sgsq_pkg::TIME_BITS_DEF,
  parameter int unsigned OFFSET_BITS = sgsq_pkg::OFFSET_BITS_DEF,
  localparam int unsigned IN_RAW     = 2 * OFFSET_BITS + sgsq_pkg::DPHASE_BITS
                                       + sgsq_pkg::MPHASE_BITS + TIME_BITS,
  localparam int unsigned IN_BITS    = ((IN_RAW + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // dx, dy, touch phase, fling phase, stamp, zero fill
  input  logic [IN_BITS-1:0]                  s_axis_tdata,
  // req_type
  input  logic                                s_axis_tuser,
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // decision, zero fill
  output logic [7:0]                          m_axis_tdata,
  // Register write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sgsq_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [sgsq_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  localparam int unsigned AB  = sgsq_pkg::ACC_BITS;
  localparam int unsigned DPB = sgsq_pkg::DPHASE_BITS;
  localparam int unsigned MPB = sgsq_pkg::MPHASE_BITS;
  localparam int unsigned DRB = sgsq_pkg::DIR_BITS;
  localparam int unsigned DCB = sgsq_pkg::DEC_BITS;
  localparam int unsigned Y_LO  = OFFSET_BITS;
  localparam int unsigned DP_LO = 2 * OFFSET_BITS;
  localparam int unsigned MP_LO = DP_LO + DPB;
  localparam int unsigned T_LO  = MP_LO + MPB;

  // Configuration registers
  logic                  enable_q;
  logic [AB-1:0]         threshold_q;
  logic [AB-1:0]         min_intv_q;
  logic [AB-1:0]         timeout_q;
  logic                  cfg_wr;
  logic                  cfg_hit;

  // Input register
  logic                  in_valid_q;
  logic                  in_req_q;
  logic [OFFSET_BITS-1:0] in_x_q;
  logic [OFFSET_BITS-1:0] in_y_q;
  logic [DPB-1:0]        in_dp_q;
  logic [MPB-1:0]        in_mp_q;
  logic [TIME_BITS-1:0]  in_t_q;

  // Result register
  logic                  out_valid_q;
  logic [DCB-1:0]        out_dec_q;
  logic [DCB-1:0]        dec;

  // Gesture state
  logic [AB-1:0]         acc_q, acc_d;
  logic [DRB-1:0]        dir_q, dir_d;
  logic                  active_q, active_d;
  logic                  switched_q, switched_d;
  logic [TIME_BITS-1:0]  sw_stamp_q, sw_stamp_d;
  logic                  sw_valid_q, sw_valid_d;
  logic [TIME_BITS-1:0]  pl_stamp_q, pl_stamp_d;
  logic                  pl_valid_q, pl_valid_d;

  logic                  out_free;
  logic                  fire;
  logic                  in_take;

  // Handshake: the input stage advances whenever the result register frees up
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || fire;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(8 - DCB){1'b0}}, out_dec_q};
  assign cfg_ready_o   = 1'b1;
  assign cfg_wr        = cfg_valid_i;
  assign cfg_hit       = cfg_wr && (cfg_index_i == sgsq_pkg::REG_ENABLE
                                 || cfg_index_i == sgsq_pkg::REG_THRESHOLD
                                 || cfg_index_i == sgsq_pkg::REG_MIN_INTV
                                 || cfg_index_i == sgsq_pkg::REG_TIMEOUT);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= sgsq_pkg::RST_ENABLE;
      threshold_q <= sgsq_pkg::RST_THRESHOLD;
      min_intv_q  <= sgsq_pkg::RST_MIN_INTV;
      timeout_q   <= sgsq_pkg::RST_TIMEOUT;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        sgsq_pkg::REG_ENABLE:    enable_q    <= cfg_data_i[0];
        sgsq_pkg::REG_THRESHOLD: threshold_q <= cfg_data_i;
        sgsq_pkg::REG_MIN_INTV:  min_intv_q  <= cfg_data_i;
        sgsq_pkg::REG_TIMEOUT:   timeout_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input register: payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q <= s_axis_tuser;
      in_x_q   <= s_axis_tdata[OFFSET_BITS-1:0];
      in_y_q   <= s_axis_tdata[Y_LO +: OFFSET_BITS];
      in_dp_q  <= s_axis_tdata[DP_LO +: DPB];
      in_mp_q  <= s_axis_tdata[MP_LO +: MPB];
      in_t_q   <= s_axis_tdata[T_LO +: TIME_BITS];
    end
  end

  // Qualify one beat against the gesture state
  always_comb begin
    logic                   begins;
    logic                   ends;
    logic                   wheel_only;
    logic                   mom_only;
    logic                   neg;
    logic                   x_neg;
    logic                   y_neg;
    logic [OFFSET_BITS-1:0] mx;
    logic [OFFSET_BITS-1:0] my;
    logic [OFFSET_BITS-1:0] mag;
    logic [DRB-1:0]         dir;
    logic [AB:0]            sum;
    logic [TIME_BITS-1:0]   pl_gap;
    logic [TIME_BITS-1:0]   sw_gap;

    acc_d      = acc_q;
    dir_d      = dir_q;
    active_d   = active_q;
    switched_d = switched_q;
    sw_stamp_d = sw_stamp_q;
    sw_valid_d = sw_valid_q;
    pl_stamp_d = pl_stamp_q;
    pl_valid_d = pl_valid_q;
    dec        = sgsq_pkg::DEC_NONE;

    begins     = (in_dp_q == sgsq_pkg::DP_BEGAN) || (in_mp_q == sgsq_pkg::MP_MAY_BEGIN);
    ends       = (in_dp_q == sgsq_pkg::DP_END) || (in_mp_q == sgsq_pkg::MP_END)
                 || (in_mp_q == sgsq_pkg::MP_BLOCKED);
    wheel_only = (in_dp_q == sgsq_pkg::DP_NONE) && (in_mp_q == sgsq_pkg::MP_NONE);
    mom_only   = (in_mp_q == sgsq_pkg::MP_BEGAN) || (in_mp_q == sgsq_pkg::MP_INERTIAL);

    // Magnitudes; the most negative value maps to 2^(OFFSET_BITS-1)
    x_neg = in_x_q[OFFSET_BITS-1];
    y_neg = in_y_q[OFFSET_BITS-1];
    mx    = x_neg ? (~in_x_q + 1'b1) : in_x_q;
    my    = y_neg ? (~in_y_q + 1'b1) : in_y_q;
    // Dominant axis, x wins ties
    if (mx >= my) begin
      mag = mx;
      neg = x_neg;
    end else begin
      mag = my;
      neg = y_neg;
    end
    dir = neg ? sgsq_pkg::DIR_NEG : sgsq_pkg::DIR_POS;

    // Gaps; time going backwards counts as no gap
    pl_gap = (in_t_q >= pl_stamp_q) ? (in_t_q - pl_stamp_q) : '0;
    sw_gap = (in_t_q >= sw_stamp_q) ? (in_t_q - sw_stamp_q) : '0;
    sum    = '0;

    if (fire) begin
      if (in_req_q == sgsq_pkg::REQ_CANCEL) begin
        // Cancel: drop the gesture and the wheel stamp
        acc_d      = '0;
        dir_d      = sgsq_pkg::DIR_NONE;
        active_d   = 1'b0;
        switched_d = 1'b0;
        pl_valid_d = 1'b0;
        pl_stamp_d = '0;
      end else if (!enable_q) begin
        acc_d      = '0;
        dir_d      = sgsq_pkg::DIR_NONE;
        active_d   = 1'b0;
        switched_d = 1'b0;
      end else begin
        if (begins) begin
          active_d   = 1'b1;
          switched_d = 1'b0;
          acc_d      = '0;
          dir_d      = sgsq_pkg::DIR_NONE;
        end
        // Restart wheel accumulation after a long gap
        if (wheel_only && pl_valid_q && (pl_gap > TIME_BITS'(timeout_q))) begin
          acc_d = '0;
          dir_d = sgsq_pkg::DIR_NONE;
        end
        if (wheel_only) begin
          pl_stamp_d = in_t_q;
          pl_valid_d = 1'b1;
        end

        if (!active_d && !wheel_only) begin
          dec = sgsq_pkg::DEC_NONE;
        end else if (mom_only && !switched_d) begin
          dec = sgsq_pkg::DEC_NONE;
        end else if (active_d && switched_d) begin
          // Already switched: swallow the rest of the gesture
          if (ends) begin
            acc_d      = '0;
            dir_d      = sgsq_pkg::DIR_NONE;
            active_d   = 1'b0;
            switched_d = 1'b0;
          end
          dec = sgsq_pkg::DEC_CONSUME;
        end else if (mag == '0) begin
          if (ends) begin
            acc_d      = '0;
            dir_d      = sgsq_pkg::DIR_NONE;
            active_d   = 1'b0;
            switched_d = 1'b0;
            dec        = sgsq_pkg::DEC_CONSUME;
          end
        end else begin
          // Accumulate, restarting on a direction change, saturating
          if (dir_d != sgsq_pkg::DIR_NONE && dir_d != dir) begin
            acc_d = '0;
          end
          dir_d = dir;
          sum   = {1'b0, acc_d} + (AB + 1)'(mag);
          acc_d = sum[AB] ? '1 : sum[AB-1:0];

          if (acc_d < threshold_q) begin
            dec = (dir == sgsq_pkg::DIR_POS) ? sgsq_pkg::DEC_PREV_NEXT
                                             : sgsq_pkg::DEC_PREV_PREV;
          end else if (sw_valid_q && (sw_gap < TIME_BITS'(min_intv_q))) begin
            // Rate limited: hold off the switch
            switched_d = active_d;
            if (ends) begin
              acc_d      = '0;
              dir_d      = sgsq_pkg::DIR_NONE;
              active_d   = 1'b0;
              switched_d = 1'b0;
            end
            dec = sgsq_pkg::DEC_CONSUME;
          end else begin
            sw_stamp_d = in_t_q;
            sw_valid_d = 1'b1;
            switched_d = active_d;
            if (wheel_only || ends) begin
              acc_d = '0;
              dir_d = sgsq_pkg::DIR_NONE;
            end
            if (ends) begin
              active_d = 1'b0;
            end
            dec = (dir == sgsq_pkg::DIR_POS) ? sgsq_pkg::DEC_SW_NEXT
                                             : sgsq_pkg::DEC_SW_PREV;
          end
        end
      end
    end

    // Any register write to a defined index clears all state
    if (cfg_hit) begin
      acc_d      = '0;
      dir_d      = sgsq_pkg::DIR_NONE;
      active_d   = 1'b0;
      switched_d = 1'b0;
      sw_stamp_d = '0;
      sw_valid_d = 1'b0;
      pl_stamp_d = '0;
      pl_valid_d = 1'b0;
    end
  end

  // Gesture state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      dir_q      <= sgsq_pkg::DIR_NONE;
      active_q   <= 1'b0;
      switched_q <= 1'b0;
      sw_stamp_q <= '0;
      sw_valid_q <= 1'b0;
      pl_stamp_q <= '0;
      pl_valid_q <= 1'b0;
    end else begin
      acc_q      <= acc_d;
      dir_q      <= dir_d;
      active_q   <= active_d;
      switched_q <= switched_d;
      sw_stamp_q <= sw_stamp_d;
      sw_valid_q <= sw_valid_d;
      pl_stamp_q <= pl_stamp_d;
      pl_valid_q <= pl_valid_d;
    end
  end

  // Result register: load on fire, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_dec_q   <= sgsq_pkg::DEC_NONE;
    end else if (out_free) begin
      out_valid_q <= fire;
      if (fire) begin
        out_dec_q <= dec;
      end
    end
  end

`ifndef SYNTHESIS
  // A processed cancel leaves no gesture and no wheel stamp
  a_cancel_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_req_q == sgsq_pkg::REQ_CANCEL)
    |=> !pl_valid_q && (acc_q == '0) && (dir_q == sgsq_pkg::DIR_NONE) && !active_q)
    else $error("cancel did not clear gesture state");

  // A valid register write wipes all state
  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (acc_q == '0) && !sw_valid_q && !pl_valid_q && !switched_q)
    else $error("register write did not clear state");

  // Every qualified beat lands in the result register
  a_fire_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q && (out_dec_q == $past(dec)))
    else $error("qualified beat lost");

  // Direction never holds the unused code
  a_dir_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_q != (sgsq_pkg::DIR_POS | sgsq_pkg::DIR_NEG))
    else $error("direction register corrupt");
`endif

endmodule
